[rtl/ycc_pkg.sv]
// Shared types and constants for the pixel to YCoCg converter.
`default_nettype none
package ycc_pkg;

  typedef enum logic [2:0] {
    FMT_BGRX32 = 3'd0,
    FMT_BGRA32 = 3'd1,
    FMT_RGBX32 = 3'd2,
    FMT_RGBA32 = 3'd3,
    FMT_BGR24  = 3'd4,
    FMT_RGB24  = 3'd5,
    FMT_BGR16  = 3'd6,
    FMT_RGB16  = 3'd7
  } fmt_t;

  typedef enum logic {
    REG_PIXEL_FORMAT = 1'b0,
    REG_LOSS_SHIFT   = 1'b1
  } reg_idx_t;

  localparam logic [2:0] LOSS_SHIFT_RESET = 3'd1;
  localparam logic [7:0] ALPHA_OPAQUE     = 8'hFF;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct packed {
    logic [8:0]        y;
    logic signed [8:0] co;
    logic signed [9:0] cg;
    logic [7:0]        a;
  } diff_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] co;
    logic [7:0] cg;
    logic [7:0] a;
  } ycc_t;

endpackage
`default_nettype wire

[rtl/ycc_unpack_stage.sv]
// Stage 1: unpack raw pixel word into red, green, blue and alpha.
`default_nettype none
module ycc_unpack_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ycc_pkg::fmt_t fmt,
  input  wire logic          valid_in,
  input  wire logic [31:0]   word_in,
  input  wire logic          stall_in,
  output logic               valid_out,
  output ycc_pkg::rgba_t     data_out,
  output logic               stall_out
);

  ycc_pkg::rgba_t px;
  logic [7:0] b0, b1, b2, b3;
  logic [7:0] first, last;

  assign b0 = word_in[7:0];
  assign b1 = word_in[15:8];
  assign b2 = word_in[23:16];
  assign b3 = word_in[31:24];
  assign first = {b0[4:0], b0[4:2]};
  assign last  = {b1[7:3], b1[7:5]};

  always_comb begin
    px.a = ycc_pkg::ALPHA_OPAQUE;
    case (fmt)
      ycc_pkg::FMT_BGRX32, ycc_pkg::FMT_BGR24: begin
        px.b = b0; px.g = b1; px.r = b2;
      end
      ycc_pkg::FMT_BGRA32: begin
        px.b = b0; px.g = b1; px.r = b2; px.a = b3;
      end
      ycc_pkg::FMT_RGBX32, ycc_pkg::FMT_RGB24: begin
        px.r = b0; px.g = b1; px.b = b2;
      end
      ycc_pkg::FMT_RGBA32: begin
        px.r = b0; px.g = b1; px.b = b2; px.a = b3;
      end
      default: begin
        px.g = {b1[2:0], b0[7:5], 2'b00};
        if (fmt == ycc_pkg::FMT_BGR16) begin
          px.r = first; px.b = last;
        end else begin
          px.b = first; px.r = last;
        end
      end
    endcase
  end

  assign stall_out = valid_out && stall_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (!stall_out) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_out) begin
      data_out <= px;
    end
  end

endmodule
`default_nettype wire

[rtl/ycc_arith_stage.sv]
// Stage 2: luma sum and raw chroma differences.
`default_nettype none
module ycc_arith_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid_in,
  input  wire ycc_pkg::rgba_t data_in,
  input  wire logic           stall_in,
  output logic                valid_out,
  output ycc_pkg::diff_t      data_out,
  output logic                stall_out
);

  ycc_pkg::diff_t d;

  always_comb begin
    d.y  = {3'b000, data_in.r[7:2]} + {2'b00, data_in.g[7:1]} + {3'b000, data_in.b[7:2]};
    d.co = $signed({1'b0, data_in.r}) - $signed({1'b0, data_in.b});
    d.cg = $signed({2'b00, data_in.g}) - $signed({3'b000, data_in.r[7:1]})
         - $signed({3'b000, data_in.b[7:1]});
    d.a  = data_in.a;
  end

  assign stall_out = valid_out && stall_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (!stall_out) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_out) begin
      data_out <= d;
    end
  end

endmodule
`default_nettype wire

[rtl/ycc_sat_stage.sv]
// Stage 3: chroma shift and saturation into the output register.
`default_nettype none
module ycc_sat_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [2:0]     loss_shift,
  input  wire logic           valid_in,
  input  wire ycc_pkg::diff_t data_in,
  input  wire logic           stall_in,
  output logic                valid_out,
  output ycc_pkg::ycc_t       data_out,
  output logic                stall_out
);

  ycc_pkg::ycc_t     res;
  logic signed [8:0] co_sh;
  logic signed [9:0] cg_sh;

  assign co_sh = data_in.co >>> loss_shift;
  assign cg_sh = data_in.cg >>> loss_shift;

  always_comb begin
    res.y = (data_in.y > 9'd255) ? 8'hFF : data_in.y[7:0];
    if (co_sh > 9'sd127) begin
      res.co = 8'h7F;
    end else if (co_sh < -9'sd128) begin
      res.co = 8'h80;
    end else begin
      res.co = co_sh[7:0];
    end
    if (cg_sh > 10'sd127) begin
      res.cg = 8'h7F;
    end else if (cg_sh < -10'sd128) begin
      res.cg = 8'h80;
    end else begin
      res.cg = cg_sh[7:0];
    end
    res.a = data_in.a;
  end

  assign stall_out = valid_out && stall_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (!stall_out) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_out) begin
      data_out <= res;
    end
  end

endmodule
`default_nettype wire

[rtl/pixel_to_ycocg_converter_unit.sv]
// Top level: pixel to YCoCg converter, config registers and three-stage pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | in        | in_valid/in_stall  | pixel_word[31:0]
//  out     | out       | out_valid/out_stall| luma_out, chroma_orange_out,
//          |           |                    | chroma_green_out, alpha_out (8b each)
//  cfg     | in        | APB psel/penable   | pixel_format @0x0, color_loss_shift @0x4
//
// One request per clock while in_stall is low; an accepted word is registered by
// each stage in turn, and out_valid rises when it reaches the output register.
// Stages: unpack, add/subtract, shift and saturate (output register).
// Synchronous reset clears all stage valids and loads the register defaults.
// A stall on out holds the output stage and the unbroken run of full stages behind it;
// a stage behind a bubble moves on.
`default_nettype none
module pixel_to_ycocg_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] pixel_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       luma_out,
  output logic signed [7:0] chroma_orange_out,
  output logic signed [7:0] chroma_green_out,
  output logic [7:0]       alpha_out
);

  ycc_pkg::fmt_t  pixel_format;
  logic [2:0]     color_loss_shift;
  ycc_pkg::reg_idx_t reg_sel;
  logic           cfg_wr;

  logic           s1_valid, s1_stall;
  ycc_pkg::rgba_t s1_data;
  logic           s2_valid, s2_stall;
  ycc_pkg::diff_t s2_data;
  ycc_pkg::ycc_t  s3_data;

  assign pready  = 1'b1;
  assign reg_sel = ycc_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format     <= ycc_pkg::FMT_BGRX32;
      color_loss_shift <= ycc_pkg::LOSS_SHIFT_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        ycc_pkg::REG_PIXEL_FORMAT: pixel_format     <= ycc_pkg::fmt_t'(pwdata[2:0]);
        ycc_pkg::REG_LOSS_SHIFT:   color_loss_shift <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ycc_pkg::REG_PIXEL_FORMAT: prdata = {29'd0, pixel_format};
      ycc_pkg::REG_LOSS_SHIFT:   prdata = {29'd0, color_loss_shift};
      default:                   prdata = 32'd0;
    endcase
  end

  ycc_unpack_stage u_unpack (
    .clk       (clk),
    .rst       (rst),
    .fmt       (pixel_format),
    .valid_in  (in_valid),
    .word_in   (pixel_word),
    .stall_in  (s1_stall),
    .valid_out (s1_valid),
    .data_out  (s1_data),
    .stall_out (in_stall)
  );

  ycc_arith_stage u_arith (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (s1_valid),
    .data_in   (s1_data),
    .stall_in  (s2_stall),
    .valid_out (s2_valid),
    .data_out  (s2_data),
    .stall_out (s1_stall)
  );

  ycc_sat_stage u_sat (
    .clk        (clk),
    .rst        (rst),
    .loss_shift (color_loss_shift),
    .valid_in   (s2_valid),
    .data_in    (s2_data),
    .stall_in   (out_stall),
    .valid_out  (out_valid),
    .data_out   (s3_data),
    .stall_out  (s2_stall)
  );

  assign luma_out          = s3_data.y;
  assign chroma_orange_out = s3_data.co;
  assign chroma_green_out  = s3_data.cg;
  assign alpha_out         = s3_data.a;

`ifndef SYNTHESIS
  // back-pressure reaches the input only when the whole pipe is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && s1_valid && s2_valid))
    else $error("input stalled with a free stage");

  // luma sum tops out at 253
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (luma_out <= 8'd253))
    else $error("luma out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");

  // a stage that held under stall keeps its contents
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_stall) |=> (s2_valid && $stable(s2_data)))
    else $error("stalled stage changed");
`endif

endmodule
`default_nettype wire
